### hw/rtl/lps_pkg.sv
// Shared types and constants for the Legendre series evaluator.
// Used by lps_head, lps_cell, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int MaxOrderDefault = 63;

  // Q1.16 point limits and Q2.30 unity
  localparam logic signed [17:0] XOne   = 18'sd65536;
  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  // reciprocal table scale, Q0.24
  localparam int RecipOne = 1 << 24;

  // register map, indexed by paddr[2]
  localparam logic RegHighestOrder = 1'b0;
  localparam logic RegOnlyHighest  = 1'b1;

  // recurrence operands handed from one order to the next
  typedef struct packed {
    logic               v;
    logic signed [17:0] x;
    logic signed [31:0] p1;
    logic signed [31:0] p0;
    logic [5:0]         top;
    logic               single;
    logic               clamped;
  } link_t;

  // one result slot of the result shift line
  typedef struct packed {
    logic               v;
    logic [5:0]         order;
    logic signed [31:0] value;
    logic               last;
    logic               clamped;
  } res_t;

endpackage

### hw/rtl/lps_head.sv
// Head of the chain: clamps the point, emits P0 and P1, seeds the first cell.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_head #(
  parameter int MAX_ORDER = lps_pkg::MaxOrderDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               accept,
  input  logic signed [17:0] x_point,
  input  logic [5:0]         highest_order,
  input  logic               only_highest,
  output lps_pkg::link_t     data_out,
  output lps_pkg::res_t      res_out
);

  logic signed [17:0] x_c;
  logic               clamp_c;
  logic [5:0]         top_c;

  logic signed [17:0] hx;
  logic               hclamp;
  logic [5:0]         htop;
  logic               hsingle;
  logic               hv;
  logic               p1_pend;
  lps_pkg::res_t      res;
  logic signed [31:0] p1_val;

  always_comb begin
    x_c     = x_point;
    clamp_c = 1'b0;
    if (x_point > lps_pkg::XOne) begin
      x_c     = lps_pkg::XOne;
      clamp_c = 1'b1;
    end else if (x_point < -lps_pkg::XOne) begin
      x_c     = -lps_pkg::XOne;
      clamp_c = 1'b1;
    end
    top_c = (highest_order > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : highest_order;
  end

  // P1 = x in Q2.30
  assign p1_val = 32'(hx) <<< 14;

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      hx      <= x_c;
      hclamp  <= clamp_c;
      htop    <= top_c;
      hsingle <= only_highest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv      <= 1'b0;
      p1_pend <= 1'b0;
      res     <= '0;
    end else if (adv) begin
      if (accept) begin
        hv          <= (top_c >= 6'd2);
        p1_pend     <= (top_c >= 6'd1);
        res.v       <= !only_highest || (top_c == 6'd0);
        res.order   <= 6'd0;
        res.value   <= lps_pkg::Q30One;
        res.last    <= (top_c == 6'd0);
        res.clamped <= clamp_c;
      end else begin
        hv          <= 1'b0;
        p1_pend     <= 1'b0;
        res.v       <= p1_pend && (!hsingle || (htop == 6'd1));
        res.order   <= 6'd1;
        res.value   <= p1_val;
        res.last    <= (htop == 6'd1);
        res.clamped <= hclamp;
      end
    end
  end

  always_comb begin
    data_out.v       = hv;
    data_out.x       = hx;
    data_out.p1      = p1_val;
    data_out.p0      = lps_pkg::Q30One;
    data_out.top     = htop;
    data_out.single  = hsingle;
    data_out.clamped = hclamp;
  end

  assign res_out = res;

endmodule

### hw/rtl/lps_cell.sv
// One recurrence cell: computes P_ORDER from P_ORDER-1 and P_ORDER-2 in five
// registered steps and forwards a slot of the result shift line. Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_cell #(
  parameter int ORDER = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  lps_pkg::link_t data_in,
  input  lps_pkg::res_t  res_in,
  output lps_pkg::link_t data_out,
  output lps_pkg::res_t  res_out
);

  localparam logic signed [7:0]  OddCoef   = 8'(2 * ORDER - 1);
  localparam logic signed [7:0]  PrevCoef  = 8'(ORDER - 1);
  localparam int                 Recip     = (lps_pkg::RecipOne + ORDER / 2) / ORDER;
  localparam logic [23:0]        RecipU    = 24'(Recip);
  localparam logic signed [24:0] RecipS    = 25'(Recip);
  localparam logic [5:0]         OrderCode = 6'(ORDER);
  localparam logic signed [56:0] HalfA     = 57'sd32768;
  localparam logic signed [65:0] HalfR     = 66'sd8388608;
  localparam logic signed [41:0] SatHi     = 42'sd1073741824;

  // operands held for the whole item
  logic signed [17:0] hx;
  logic signed [24:0] hxk;
  logic signed [31:0] hp1;
  logic signed [31:0] hp0;
  logic [5:0]         htop;
  logic               hsingle;
  logic               hclamp;

  logic               s0_v, s1_v, s2_v, s3_v, out_v;
  logic signed [56:0] a;
  logic signed [37:0] q;
  logic signed [39:0] d;
  logic signed [44:0] ph;
  logic [43:0]        pl;
  logic               dneg;
  logic signed [31:0] pn;
  lps_pkg::res_t      res;

  logic signed [56:0] a_rnd;
  logic signed [39:0] d_next;
  logic signed [65:0] sum;
  logic signed [65:0] sum_rnd;
  logic signed [41:0] rq;
  logic signed [31:0] pn_next;
  logic               emit;

  // round to nearest, ties away from zero: add half, less one when negative
  always_comb begin
    a_rnd  = a + HalfA - 57'(a[56]);
    d_next = $signed(a_rnd[55:16]) - 40'(q);
  end

  always_comb begin
    sum     = (66'(ph) <<< 20) + $signed({22'd0, pl});
    sum_rnd = sum + HalfR - 66'(dneg);
    rq      = $signed(sum_rnd[65:24]);
    if (rq > SatHi) begin
      pn_next = lps_pkg::Q30One;
    end else if (rq < -SatHi) begin
      pn_next = -lps_pkg::Q30One;
    end else begin
      pn_next = rq[31:0];
    end
    emit = (OrderCode <= htop) && (!hsingle || (OrderCode == htop));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (data_in.v) begin
        hx      <= data_in.x;
        hxk     <= 25'(data_in.x) * 25'(OddCoef);
        hp1     <= data_in.p1;
        hp0     <= data_in.p0;
        htop    <= data_in.top;
        hsingle <= data_in.single;
        hclamp  <= data_in.clamped;
      end
      a    <= 57'(hxk) * 57'(hp1);
      q    <= 38'(hp0) * 38'(PrevCoef);
      d    <= d_next;
      // signed upper half times reciprocal, unsigned lower half times reciprocal
      ph   <= 45'($signed(d[39:20])) * 45'(RecipS);
      pl   <= 44'(d[19:0]) * 44'(RecipU);
      dneg <= d[39];
      if (s3_v) begin
        pn <= pn_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v  <= 1'b0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      out_v <= 1'b0;
      res   <= '0;
    end else if (adv) begin
      s0_v  <= data_in.v;
      s1_v  <= s0_v;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      out_v <= s3_v && (OrderCode < htop);
      // own result never meets a passing one: their arrival times differ
      if (s3_v && emit) begin
        res.v       <= 1'b1;
        res.order   <= OrderCode;
        res.value   <= pn_next;
        res.last    <= (OrderCode == htop);
        res.clamped <= hclamp;
      end else begin
        res <= res_in;
      end
    end
  end

  always_comb begin
    data_out.v       = out_v;
    data_out.x       = hx;
    data_out.p1      = pn;
    data_out.p0      = hp1;
    data_out.top     = htop;
    data_out.single  = hsingle;
    data_out.clamped = hclamp;
  end

  assign res_out = res;

endmodule

### hw/rtl/legendre_polynomial_series.sv
// Top level of the Legendre series evaluator: APB registers, head and cell chain.
// Depends on lps_pkg, lps_head and lps_cell.
//
// Usage: a request on the input channel (in_valid/in_ready, x_point in Q1.16)
// is one point. The block clamps it to +/-1.0 and returns P_0..P_N (or only
// P_N when only_highest is set) on the output channel, one order per transfer,
// last_of_run marking the final one. N is highest_order, capped at MAX_ORDER.
// A row of MAX_ORDER-1 cells, one per order from 2 up, each works through its
// step of the recurrence in registered stages; results ride a shift line of one
// slot in the head and one per cell, so P_0 and P_1 cross every slot and P_n
// (n >= 2) joins the line at its cell. One point is in flight at a time: in_ready
// returns the cycle after the last result is taken. When the receiver stalls,
// the whole chain holds; nothing is lost. Reset (rst, synchronous) empties the
// chain and sets highest_order to 1, only_highest to 0. Registers: 0x0
// highest_order, 0x4 only_highest.
`timescale 1ns / 1ps

module legendre_polynomial_series #(
  parameter int MAX_ORDER = lps_pkg::MaxOrderDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] x_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         order_index,
  output logic signed [31:0] poly_value,
  output logic               last_of_run,
  output logic               was_clamped
);

  localparam int NumCells = MAX_ORDER - 1;

  logic [5:0]     highest_order;
  logic           only_highest;
  logic           busy;
  logic           adv;
  logic           accept;
  lps_pkg::link_t link  [MAX_ORDER];
  lps_pkg::res_t  rlink [MAX_ORDER];
  lps_pkg::res_t  tail;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_order <= 6'd1;
      only_highest  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        lps_pkg::RegHighestOrder: highest_order <= pwdata[5:0];
        lps_pkg::RegOnlyHighest:  only_highest  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lps_pkg::RegHighestOrder: prdata = {26'd0, highest_order};
      lps_pkg::RegOnlyHighest:  prdata = {31'd0, only_highest};
      default:                  prdata = '0;
    endcase
  end

  assign tail      = rlink[MAX_ORDER-1];
  assign out_valid = tail.v;
  assign adv       = !tail.v || out_ready;
  assign in_ready  = !busy;
  assign accept    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (tail.v && out_ready && tail.last) begin
      busy <= 1'b0;
    end
  end

  lps_head #(
    .MAX_ORDER(MAX_ORDER)
  ) u_head (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .accept       (accept),
    .x_point      (x_point),
    .highest_order(highest_order),
    .only_highest (only_highest),
    .data_out     (link[0]),
    .res_out      (rlink[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    lps_cell #(
      .ORDER(k + 2)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .data_in (link[k]),
      .res_in  (rlink[k]),
      .data_out(link[k+1]),
      .res_out (rlink[k+1])
    );
  end

  assign order_index = tail.order;
  assign poly_value  = tail.value;
  assign last_of_run = tail.last;
  assign was_clamped = tail.clamped;

endmodule

### hw/rtl/lps_checker.sv
// Port-level checks for legendre_polynomial_series, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module lps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [5:0]         order_index,
  input logic signed [31:0] poly_value,
  input logic               last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(poly_value) && $stable(order_index))
    else $error("stalled result changed");

  // no new point while results of the current one are pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready with result pending");

  a_take_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second point taken while busy");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_run |=> in_ready)
    else $error("input not ready after last result");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (poly_value <= 32'sd1073741824) && (poly_value >= -32'sd1073741824))
    else $error("value beyond saturation bound");

endmodule

bind legendre_polynomial_series lps_checker u_checker (.*);

### dv/legendre_polynomial_series_tb.sv
// Testbench for legendre_polynomial_series: drives points, predicts every P_n value
// and compares results field by field. Depends on lps_pkg and the top-level RTL.
`timescale 1ns / 1ps

module legendre_polynomial_series_tb;

  localparam int MaxOrder = lps_pkg::MaxOrderDefault;
  localparam longint CycleLimit = 1000000;
  // Q1.16 point to Q2.30 value
  localparam longint PointToQ30 = 16384;

  typedef struct {
    logic [5:0]         order;
    logic signed [31:0] value;
    logic               last;
    logic               clamped;
  } poly_result_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic signed [17:0] x_point;
  logic               out_valid;
  logic               out_ready;
  logic [5:0]         order_index;
  logic signed [31:0] poly_value;
  logic               last_of_run;
  logic               was_clamped;

  poly_result_t expected_values[$];
  logic [5:0]   cfg_highest_order = 6'd1;
  logic         cfg_only_highest = 1'b0;
  bit           idle_on = 1'b1;
  int           error_count = 0;
  int           points_sent = 0;
  int           values_checked = 0;
  longint       cycle_count = 0;

  legendre_polynomial_series #(
    .MAX_ORDER(MaxOrder)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_point    (x_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .order_index(order_index),
    .poly_value (poly_value),
    .last_of_run(last_of_run),
    .was_clamped(was_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d values pending", cycle_count,
               expected_values.size());
      $display("legendre_polynomial_series_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  // round to nearest, ties away from zero
  function automatic longint round_shift_nearest(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint clip_unity(longint v);
    if (v > longint'(lps_pkg::Q30One)) return longint'(lps_pkg::Q30One);
    if (v < -longint'(lps_pkg::Q30One)) return -longint'(lps_pkg::Q30One);
    return v;
  endfunction

  function automatic void queue_value(int order, longint v, bit last, bit clamped);
    poly_result_t r;
    r.order   = order[5:0];
    r.value   = v[31:0];
    r.last    = last;
    r.clamped = clamped;
    expected_values.push_back(r);
  endfunction

  function automatic void predict_point(logic signed [17:0] xin);
    longint x;
    longint p_nm2;
    longint p_nm1;
    longint a;
    longint d;
    longint pn;
    longint recip;
    int     top;
    bit     single;
    bit     clamped;
    x = xin;
    clamped = 1'b0;
    if (x > longint'(lps_pkg::XOne)) begin
      x = lps_pkg::XOne;
      clamped = 1'b1;
    end else if (x < -longint'(lps_pkg::XOne)) begin
      x = -longint'(lps_pkg::XOne);
      clamped = 1'b1;
    end
    top = cfg_highest_order;
    if (top > MaxOrder) top = MaxOrder;
    single = cfg_only_highest;
    p_nm2 = lps_pkg::Q30One;
    if (!single || top == 0) queue_value(0, p_nm2, top == 0, clamped);
    p_nm1 = p_nm2;
    if (top >= 1) begin
      p_nm1 = x * PointToQ30;
      if (!single || top == 1) queue_value(1, p_nm1, top == 1, clamped);
    end
    for (int n = 2; n <= top; n++) begin
      recip = (longint'(lps_pkg::RecipOne) + n / 2) / n;
      a = round_shift_nearest(longint'(2 * n - 1) * x * p_nm1, 16);
      d = a - longint'(n - 1) * p_nm2;
      pn = clip_unity(round_shift_nearest(d * recip, 24));
      p_nm2 = p_nm1;
      p_nm1 = pn;
      if (!single || n == top) queue_value(n, pn, n == top, clamped);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d, %s: got %0d, want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_values
    poly_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("value with no point pending, order", order_index, -1);
      end else begin
        want = expected_values.pop_front();
        values_checked++;
        if (order_index !== want.order)
          report_mismatch("order_index", order_index, want.order);
        if (poly_value !== want.value)
          report_mismatch($sformatf("poly_value of order %0d", want.order), poly_value,
                          want.value);
        if (last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run of order %0d", want.order), last_of_run,
                          want.last);
        if (was_clamped !== want.clamped)
          report_mismatch($sformatf("was_clamped of order %0d", want.order), was_clamped,
                          want.clamped);
      end
    end
  end

  // receiver stalls in bursts while idling is on
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_values.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_config(int order, bit single);
    logic [31:0] data;
    wait_drained();
    // upper bits are don't-care, register keeps the low six
    data = {$urandom()} & 32'hFFFF_FFC0;
    data[5:0] = order[5:0];
    apb_write({lps_pkg::RegHighestOrder, 2'b00}, data);
    apb_write({lps_pkg::RegOnlyHighest, 2'b00}, {31'd0, single});
    cfg_highest_order = order[5:0];
    cfg_only_highest  = single;
  endtask

  task automatic send_point(logic signed [17:0] x);
    in_valid <= 1'b1;
    x_point  <= x;
    do @(posedge clk); while (!in_ready);
    predict_point(x);
    points_sent++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic end_points();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [17:0] random_point();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 131072)) - 65536;
      6: v = int'($urandom_range(65537, 131071));
      7: v = -int'($urandom_range(65537, 131072));
      8: v = ($urandom_range(0, 1) ? 1 : -1) * (65536 - int'($urandom_range(0, 64)));
      default: v = int'($urandom());
    endcase
    return v[17:0];
  endfunction

  // mostly short series, a few long ones
  function automatic int random_order();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 8);
      6, 7: return $urandom_range(9, 31);
      8: return $urandom_range(32, MaxOrder - 1);
      default: return MaxOrder;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset values: orders 0 and 1, series mode
  task automatic test_reset_defaults();
    send_point(18'sd0);
    send_point(18'sd32768);
    send_point(-18'sd32768);
    end_points();
  endtask

  task automatic test_point_extremes();
    set_config(4, 1'b0);
    send_point(18'sd65536);
    send_point(-18'sd65536);
    send_point(18'sd65537);
    send_point(-18'sd65537);
    send_point(18'sd131071);
    send_point(-18'sd131072);
    send_point(18'sd1);
    send_point(-18'sd1);
    end_points();
  endtask

  // order zero gives a single P_0 marked last in both modes
  task automatic test_order_zero();
    set_config(0, 1'b0);
    send_point(18'sd12345);
    send_point(-18'sd131072);
    end_points();
    set_config(0, 1'b1);
    send_point(18'sd65536);
    end_points();
  endtask

  task automatic test_top_order();
    set_config(MaxOrder, 1'b0);
    send_point(18'sd65536);
    send_point(-18'sd65536);
    send_point(18'sd40000);
    end_points();
    set_config(MaxOrder, 1'b1);
    send_point(-18'sd20000);
    send_point(18'sd131071);
    end_points();
  endtask

  task automatic test_single_low();
    set_config(2, 1'b1);
    send_point(18'sd0);
    end_points();
    set_config(1, 1'b1);
    send_point(-18'sd45000);
    end_points();
  endtask

  task automatic test_random_phases(int count, bit idling);
    int target;
    target = points_sent + count;
    while (points_sent < target) begin
      set_config(random_order(), $urandom_range(0, 3) == 0);
      idle_on = idling && ($urandom_range(0, 4) != 0);
      repeat ($urandom_range(6, 14)) send_point(random_point());
      end_points();
    end
  endtask

  initial begin
    rst     <= 1'b1;
    in_valid <= 1'b0;
    x_point <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_point_extremes();
    test_order_zero();
    test_top_order();
    test_single_low();
    test_random_phases(150, 1'b1);
    wait_drained();
    test_random_phases(40, 1'b0);

    wait_drained();
    repeat (MaxOrder + 16) @(posedge clk);
    $display("summary: %0d points sent, %0d values checked, orders 0 to %0d,",
             points_sent, values_checked, MaxOrder);
    $display("summary: series and single modes, clamped points, with and without stalls");
    if (error_count == 0) begin
      $display("legendre_polynomial_series_tb: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("legendre_polynomial_series_tb: errors");
    end
    $finish;
  end

endmodule

### legendre_polynomial_series.f
hw/rtl/lps_pkg.sv
hw/rtl/lps_head.sv
hw/rtl/lps_cell.sv
hw/rtl/legendre_polynomial_series.sv
hw/rtl/lps_checker.sv
dv/legendre_polynomial_series_tb.sv
